FILE: design/wpre_pkg.sv
package wpre_pkg;

   localparam int MAX_POINTS_DEFAULT = 64;

   localparam int IDX_W     = 6;
   localparam int COORD_W   = 16;
   localparam int WEIGHT_W  = 16;
   localparam int ENERGY_W  = 40;
   localparam int GRAD_W    = 32;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int U_W       = 34;
   localparam int DIV_NUM_W = 83;
   localparam int T_W       = 33;
   localparam int NUM_AXES  = 3;
   localparam int PT_W      = NUM_AXES * COORD_W;
   localparam int GR_W      = NUM_AXES * GRAD_W;

   localparam int ENERGY_SHIFT = 36;
   localparam int GRAD_SHIFT   = 50;

   localparam logic [1:0] AXIS_LAST = 2'd2;

   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_PAIR  = 2'd1,
      ACT_READ  = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      DIV_ENERGY      = 2'd0,
      DIV_GRAD_FIRST  = 2'd1,
      DIV_GRAD_SECOND = 2'd2
   } div_src_type;

   typedef struct packed {
      logic        capture;
      logic        pt_write;
      logic        pt_rd_b;
      logic        cap_a;
      logic        cap_diff;
      logic        sq_en;
      logic [1:0]  axis;
      logic        div_start;
      div_src_type div_src;
      logic        en_update;
      logic        t_capture;
      logic        gr_rd_b;
      logic        gr_write;
      logic        gr_wr_b;
      logic        read_capture;
      logic        clr_acc;
      logic        clr_step;
      logic        set_flag;
   } ctrl_cmd_type;

   typedef struct packed {
      action_type action;
      logic       a_ok;
      logic       b_ok;
      logic       u_zero;
      logic       div_done;
      logic       clr_last;
   } dp_status_type;

endpackage

FILE: design/wpre_ram.sv
module wpre_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/wpre_div.sv
module wpre_div #(
   parameter int NUM_W = 83,
   parameter int DEN_W = 34
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   trial;
   logic             ge;
   logic             running;

   assign running = (cnt_ff != '0);
   assign trial   = {rem_ff, quo_ff[NUM_W-1]};
   assign ge      = (trial >= {1'b0, denom});

   always_comb begin
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = CNT_W'(NUM_W);
         rem_in = '0;
         quo_in = numer;
      end else if (running) begin
         // restoring step: one quotient bit a cycle
         rem_in  = ge ? DEN_W'(trial - {1'b0, denom}) : trial[DEN_W-1:0];
         quo_in  = {quo_ff[NUM_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !running)
      else $error("divider restarted while running");

endmodule

FILE: design/wpre_datapath.sv
module wpre_datapath #(
   parameter int MAX_POINTS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  wpre_pkg::ctrl_cmd_type             cmd,
   output wpre_pkg::dp_status_type            status,
   input  logic [1:0]                         req_action,
   input  logic [wpre_pkg::IDX_W-1:0]         req_point_index,
   input  logic [wpre_pkg::IDX_W-1:0]         req_second_index,
   input  logic signed [wpre_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [wpre_pkg::COORD_W-1:0] req_coord_y,
   input  logic signed [wpre_pkg::COORD_W-1:0] req_coord_z,
   input  logic [wpre_pkg::WEIGHT_W-1:0]      req_pair_weight,
   output logic [wpre_pkg::ENERGY_W-1:0]      rsp_energy_total,
   output logic signed [wpre_pkg::GRAD_W-1:0] rsp_grad_x,
   output logic signed [wpre_pkg::GRAD_W-1:0] rsp_grad_y,
   output logic signed [wpre_pkg::GRAD_W-1:0] rsp_grad_z,
   output logic                               rsp_coincident_flag
);

   import wpre_pkg::*;

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

   function automatic logic signed [GRAD_W-1:0] sat_add(
      input logic signed [GRAD_W-1:0] g,
      input logic signed [T_W:0]      delta
   );
      logic signed [T_W+1:0] s;
      s = (T_W+2)'(g) + (T_W+2)'(delta);
      if (s > (T_W+2)'(signed'({1'b0, {(GRAD_W-1){1'b1}}}))) begin
         return {1'b0, {(GRAD_W-1){1'b1}}};
      end else if (s < (T_W+2)'(signed'({1'b1, {(GRAD_W-1){1'b0}}}))) begin
         return {1'b1, {(GRAD_W-1){1'b0}}};
      end
      return s[GRAD_W-1:0];
   endfunction

   // captured request
   action_type                 action_ff;
   logic [IDX_W-1:0]           a_idx_ff, b_idx_ff;
   logic signed [COORD_W-1:0]  cx_ff, cy_ff, cz_ff;
   logic [WEIGHT_W-1:0]        w_ff;

   // pair arithmetic
   logic signed [COORD_W-1:0]  pa_ff [NUM_AXES];
   logic signed [DIFF_W-1:0]   d_ff  [NUM_AXES];
   logic [U_W-1:0]             u_ff;
   logic [T_W-1:0]             t_ff  [NUM_AXES];
   logic                       neg_ff [NUM_AXES];

   // accumulators and outputs
   logic [ENERGY_W-1:0]        energy_ff;
   logic                       flag_ff;
   logic signed [GRAD_W-1:0]   gout_ff [NUM_AXES];
   logic [AW-1:0]              clr_cnt_ff;

   logic [AW-1:0]              a_addr, b_addr;
   logic [PT_W-1:0]            pt_rdata;
   logic [GR_W-1:0]            gr_rdata, gr_wdata, gr_new;
   logic                       gr_wen;
   logic [AW-1:0]              gr_waddr;

   logic signed [DIFF_W-1:0]   d_sel;
   logic signed [2*DIFF_W-1:0] sq;
   logic [DIFF_W-1:0]          mag;
   logic [GRAD_W-1:0]          wm;
   logic [DIV_NUM_W-1:0]       div_numer, div_quot;
   logic                       div_done;
   logic [ENERGY_W:0]          en_sum;
   logic                       en_sat;
   logic [T_W-1:0]             t_cap;
   logic                       t_over;

   assign a_addr = AW'(a_idx_ff);
   assign b_addr = AW'(b_idx_ff);

   wpre_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_point_ram (
      .clock   (clock),
      .wr_en   (cmd.pt_write),
      .wr_addr (a_addr),
      .wr_data ({cz_ff, cy_ff, cx_ff}),
      .rd_addr (cmd.pt_rd_b ? b_addr : a_addr),
      .rd_data (pt_rdata)
   );

   assign gr_wen   = cmd.clr_step | cmd.gr_write;
   assign gr_waddr = cmd.clr_step ? clr_cnt_ff : (cmd.gr_wr_b ? b_addr : a_addr);
   assign gr_wdata = cmd.clr_step ? '0 : gr_new;

   wpre_ram #(.WIDTH(GR_W), .DEPTH(MAX_POINTS)) u_grad_ram (
      .clock   (clock),
      .wr_en   (gr_wen),
      .wr_addr (gr_waddr),
      .wr_data (gr_wdata),
      .rd_addr (cmd.gr_rd_b ? b_addr : a_addr),
      .rd_data (gr_rdata)
   );

   // point a gets the negated term, point b the term itself
   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
         if (neg_ff[k] ^ cmd.gr_wr_b) begin
            gr_new[k*GRAD_W +: GRAD_W] =
               sat_add(signed'(gr_rdata[k*GRAD_W +: GRAD_W]), signed'({1'b0, t_ff[k]}));
         end else begin
            gr_new[k*GRAD_W +: GRAD_W] =
               sat_add(signed'(gr_rdata[k*GRAD_W +: GRAD_W]), -signed'({1'b0, t_ff[k]}));
         end
      end
   end

   assign d_sel = d_ff[cmd.axis];
   assign sq    = d_sel * d_sel;
   assign mag   = d_sel[DIFF_W-1] ? DIFF_W'(-d_sel) : DIFF_W'(d_sel);
   assign wm    = GRAD_W'(w_ff * mag);

   always_comb begin
      case (cmd.div_src)
         DIV_ENERGY:
            div_numer = DIV_NUM_W'({w_ff, {ENERGY_SHIFT{1'b0}}});
         DIV_GRAD_FIRST:
            div_numer = DIV_NUM_W'({wm, 1'b0, {GRAD_SHIFT{1'b0}}});
         DIV_GRAD_SECOND:
            div_numer = div_quot;
         default:
            div_numer = '0;
      endcase
   end

   wpre_div #(.NUM_W(DIV_NUM_W), .DEN_W(U_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .numer (div_numer),
      .denom (u_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign en_sum = {1'b0, energy_ff} + {1'b0, div_quot[ENERGY_W-1:0]};
   assign en_sat = (|div_quot[DIV_NUM_W-1:ENERGY_W]) | en_sum[ENERGY_W];
   // magnitude is capped at 2^32
   assign t_over = (|div_quot[DIV_NUM_W-1:T_W]) |
                   (div_quot[T_W-1] & (|div_quot[T_W-2:0]));
   assign t_cap  = t_over ? {1'b1, {(T_W-1){1'b0}}} : div_quot[T_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         energy_ff  <= '0;
         flag_ff    <= 1'b0;
         clr_cnt_ff <= '0;
      end else begin
         if (cmd.clr_acc) begin
            energy_ff <= '0;
            flag_ff   <= 1'b0;
         end else begin
            if (cmd.en_update) begin
               energy_ff <= en_sat ? '1 : en_sum[ENERGY_W-1:0];
            end
            if (cmd.set_flag) begin
               flag_ff <= 1'b1;
            end
         end
         if (cmd.clr_step) begin
            clr_cnt_ff <= status.clr_last ? '0 : clr_cnt_ff + 1'b1;
         end
      end

      if (cmd.capture) begin
         action_ff <= action_type'(req_action);
         a_idx_ff  <= req_point_index;
         b_idx_ff  <= req_second_index;
         cx_ff     <= req_coord_x;
         cy_ff     <= req_coord_y;
         cz_ff     <= req_coord_z;
         w_ff      <= req_pair_weight;
         for (int k = 0; k < NUM_AXES; k++) begin
            gout_ff[k] <= '0;
         end
      end
      if (cmd.read_capture) begin
         for (int k = 0; k < NUM_AXES; k++) begin
            gout_ff[k] <= signed'(gr_rdata[k*GRAD_W +: GRAD_W]);
         end
      end
      if (cmd.cap_a) begin
         for (int k = 0; k < NUM_AXES; k++) begin
            pa_ff[k] <= signed'(pt_rdata[k*COORD_W +: COORD_W]);
         end
      end
      if (cmd.cap_diff) begin
         for (int k = 0; k < NUM_AXES; k++) begin
            d_ff[k] <= DIFF_W'(pa_ff[k]) - DIFF_W'(signed'(pt_rdata[k*COORD_W +: COORD_W]));
         end
         u_ff <= '0;
      end
      if (cmd.sq_en) begin
         u_ff <= u_ff + U_W'(unsigned'(sq));
      end
      if (cmd.t_capture) begin
         t_ff[cmd.axis]   <= t_cap;
         neg_ff[cmd.axis] <= d_sel[DIFF_W-1];
      end
   end

   assign status.action   = action_ff;
   assign status.a_ok     = (32'(a_idx_ff) < 32'(MAX_POINTS));
   assign status.b_ok     = (32'(b_idx_ff) < 32'(MAX_POINTS));
   assign status.u_zero   = (u_ff == '0);
   assign status.div_done = div_done;
   assign status.clr_last = (clr_cnt_ff == AW'(MAX_POINTS - 1));

   assign rsp_energy_total    = energy_ff;
   assign rsp_grad_x          = gout_ff[0];
   assign rsp_grad_y          = gout_ff[1];
   assign rsp_grad_z          = gout_ff[2];
   assign rsp_coincident_flag = flag_ff;

   a_one_grad_writer: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clr_step && cmd.gr_write))
      else $error("gradient store written by sweep and update together");

endmodule

FILE: design/wpre_ctrl.sv
module wpre_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output logic                    rsp_valid,
   output wpre_pkg::ctrl_cmd_type  cmd,
   input  wpre_pkg::dp_status_type status
);

   import wpre_pkg::*;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_RD_GR, S_RD_CAP,
      S_PT_A, S_PT_B, S_DIFF, S_SQ, S_CHECK,
      S_DIV_E, S_G1, S_G1_W, S_G2, S_G2_W,
      S_GA_RD, S_GA_WR, S_GB_WR, S_RESP
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic       pend_ff, pend_in;
   logic       busy_ff, rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      pend_in  = pend_ff;
      cmd      = '0;
      cmd.axis = axis_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = pend_ff ? S_RESP : S_IDLE;
               pend_in  = 1'b0;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (status.action)
               ACT_LOAD: begin
                  cmd.pt_write = status.a_ok;
                  state_in     = S_RESP;
               end
               ACT_PAIR: state_in = (status.a_ok && status.b_ok) ? S_PT_A : S_RESP;
               ACT_READ: state_in = status.a_ok ? S_RD_GR : S_RESP;
               ACT_CLEAR: begin
                  cmd.clr_acc = 1'b1;
                  pend_in     = 1'b1;
                  state_in    = S_CLEAR;
               end
               default: state_in = S_RESP;
            endcase
         end
         S_RD_GR: state_in = S_RD_CAP;
         S_RD_CAP: begin
            cmd.read_capture = 1'b1;
            state_in         = S_RESP;
         end
         S_PT_A: state_in = S_PT_B;
         S_PT_B: begin
            cmd.pt_rd_b = 1'b1;
            cmd.cap_a   = 1'b1;
            state_in    = S_DIFF;
         end
         S_DIFF: begin
            cmd.cap_diff = 1'b1;
            axis_in      = '0;
            state_in     = S_SQ;
         end
         S_SQ: begin
            cmd.sq_en = 1'b1;
            if (axis_ff == AXIS_LAST) begin
               axis_in  = '0;
               state_in = S_CHECK;
            end else begin
               axis_in = axis_ff + 1'b1;
            end
         end
         S_CHECK: begin
            if (status.u_zero) begin
               cmd.set_flag = 1'b1;
               state_in     = S_RESP;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_src   = DIV_ENERGY;
               state_in      = S_DIV_E;
            end
         end
         S_DIV_E: begin
            if (status.div_done) begin
               cmd.en_update = 1'b1;
               state_in      = S_G1;
            end
         end
         S_G1: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = DIV_GRAD_FIRST;
            state_in      = S_G1_W;
         end
         S_G1_W: begin
            if (status.div_done) begin
               state_in = S_G2;
            end
         end
         S_G2: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = DIV_GRAD_SECOND;
            state_in      = S_G2_W;
         end
         S_G2_W: begin
            if (status.div_done) begin
               cmd.t_capture = 1'b1;
               if (axis_ff == AXIS_LAST) begin
                  axis_in  = '0;
                  state_in = S_GA_RD;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = S_G1;
               end
            end
         end
         S_GA_RD: state_in = S_GA_WR;
         S_GA_WR: begin
            // write a while b is being read
            cmd.gr_write = 1'b1;
            cmd.gr_rd_b  = 1'b1;
            state_in     = S_GB_WR;
         end
         S_GB_WR: begin
            cmd.gr_write = 1'b1;
            cmd.gr_wr_b  = 1'b1;
            state_in     = S_RESP;
         end
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         axis_ff      <= '0;
         pend_ff      <= 1'b0;
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         pend_ff      <= pend_in;
         busy_ff      <= (state_in != S_IDLE);
         rsp_valid_ff <= (state_in == S_RESP);
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy_ff) |=> busy_ff)
      else $error("busy not raised after accept");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe longer than one cycle");

endmodule

FILE: design/weighted_pair_repulsion_energy.sv
// throughput: one item at a time; a pair is set by seven passes of the 83-step
// serial divider, a clear by the one-entry-a-cycle sweep of the gradient memory
// reset: synchronous, active high; afterwards the gradient memory is swept to zero
// with busy high; results cannot be stalled by the receiver
module weighted_pair_repulsion_energy #(
   parameter int MAX_POINTS = wpre_pkg::MAX_POINTS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_action,
   input  logic [wpre_pkg::IDX_W-1:0]          req_point_index,
   input  logic [wpre_pkg::IDX_W-1:0]          req_second_index,
   input  logic signed [wpre_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [wpre_pkg::COORD_W-1:0] req_coord_y,
   input  logic signed [wpre_pkg::COORD_W-1:0] req_coord_z,
   input  logic [wpre_pkg::WEIGHT_W-1:0]       req_pair_weight,
   output logic                                rsp_valid,
   output logic [wpre_pkg::ENERGY_W-1:0]       rsp_energy_total,
   output logic signed [wpre_pkg::GRAD_W-1:0]  rsp_grad_x,
   output logic signed [wpre_pkg::GRAD_W-1:0]  rsp_grad_y,
   output logic signed [wpre_pkg::GRAD_W-1:0]  rsp_grad_z,
   output logic                                rsp_coincident_flag
);

   import wpre_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   wpre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   wpre_datapath #(.MAX_POINTS(MAX_POINTS)) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_action          (req_action),
      .req_point_index     (req_point_index),
      .req_second_index    (req_second_index),
      .req_coord_x         (req_coord_x),
      .req_coord_y         (req_coord_y),
      .req_coord_z         (req_coord_z),
      .req_pair_weight     (req_pair_weight),
      .rsp_energy_total    (rsp_energy_total),
      .rsp_grad_x          (rsp_grad_x),
      .rsp_grad_y          (rsp_grad_y),
      .rsp_grad_z          (rsp_grad_z),
      .rsp_coincident_flag (rsp_coincident_flag)
   );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import wpre_pkg::*;

   localparam int NPTS       = 64;
   localparam int RAND_WORDS = 900;
   localparam int DRAIN      = 700;
   localparam longint CYCLE_LIMIT = 2500000;

   typedef struct {
      logic [39:0]        energy;
      logic signed [31:0] gx;
      logic signed [31:0] gy;
      logic signed [31:0] gz;
      logic               flag;
   } result_word;

   class pair_energy_scoreboard;
      logic signed [15:0] coords[NPTS][3];
      longint             grads[NPTS][3];
      logic [39:0]        energy;
      bit                 flag;
      result_word         pending[$];
      int                 errors;
      int                 checked;
      int                 per_action[4];
      int                 coincident_pairs;

      function new();
         energy = '0;
         flag = 0;
         errors = 0;
         checked = 0;
         coincident_pairs = 0;
         foreach (grads[i, k]) grads[i][k] = 0;
         foreach (coords[i, k]) coords[i][k] = '0;
         foreach (per_action[i]) per_action[i] = 0;
      endfunction

      function longint clamp32(longint s);
         if (s > 64'sd2147483647) return 64'sd2147483647;
         if (s < -64'sd2147483648) return -64'sd2147483648;
         return s;
      endfunction

      function void add_pair(int a, int b, logic [15:0] w);
         logic signed [16:0] d[3];
         logic [16:0]        mag[3];
         logic [33:0]        u;
         logic [63:0]        eterm;
         logic [63:0]        esum;
         logic [127:0]       num;
         logic [127:0]       den;
         logic [127:0]       q;
         longint             t;
         u = '0;
         for (int k = 0; k < 3; k++) begin
            d[k] = {coords[a][k][15], coords[a][k]} - {coords[b][k][15], coords[b][k]};
            mag[k] = d[k] < 0 ? 17'(-d[k]) : 17'(d[k]);
            u = u + 34'(mag[k]) * 34'(mag[k]);
         end
         if (u == 0) begin
            flag = 1;
            coincident_pairs++;
            return;
         end
         eterm = (64'(w) << 36) / 64'(u);
         esum = 64'(energy) + eterm;
         energy = esum > 64'hFF_FFFF_FFFF ? 40'hFF_FFFF_FFFF : esum[39:0];
         den = 128'(u) * 128'(u);
         for (int k = 0; k < 3; k++) begin
            num = (128'(w) * 128'(mag[k]) * 128'd2) << 50;
            q = num / den;
            if (q > 128'h1_0000_0000) q = 128'h1_0000_0000;
            t = longint'(q[63:0]);
            if (d[k] < 0) t = -t;
            grads[a][k] = clamp32(grads[a][k] - t);
            grads[b][k] = clamp32(grads[b][k] + t);
         end
      endfunction

      function void note_word(action_type act, int a, int b, logic [15:0] x,
                              logic [15:0] y, logic [15:0] z, logic [15:0] w);
         result_word r;
         r.gx = '0;
         r.gy = '0;
         r.gz = '0;
         per_action[act]++;
         case (act)
            ACT_LOAD: begin
               coords[a][0] = x;
               coords[a][1] = y;
               coords[a][2] = z;
            end
            ACT_PAIR: add_pair(a, b, w);
            ACT_READ: begin
               r.gx = grads[a][0][31:0];
               r.gy = grads[a][1][31:0];
               r.gz = grads[a][2][31:0];
            end
            default: begin
               foreach (grads[i, k]) grads[i][k] = 0;
               energy = '0;
               flag = 0;
            end
         endcase
         r.energy = energy;
         r.flag = flag;
         pending.push_back(r);
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         errors++;
         $display("mismatch at word %0d: %s got %h expected %h", checked, what, got, want);
      endtask

      task check_word(result_word got);
         result_word want;
         if (pending.size() == 0) begin
            report("unexpected result", 0, 0);
            return;
         end
         want = pending.pop_front();
         if (got.energy !== want.energy) report("energy_total", got.energy, want.energy);
         if (got.gx !== want.gx) report("grad_x", 64'(got.gx), 64'(want.gx));
         if (got.gy !== want.gy) report("grad_y", 64'(got.gy), 64'(want.gy));
         if (got.gz !== want.gz) report("grad_z", 64'(got.gz), 64'(want.gz));
         if (got.flag !== want.flag) report("coincident_flag", got.flag, want.flag);
         checked++;
      endtask
   endclass

   logic        clock = 0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_action;
   logic [5:0]  req_point_index;
   logic [5:0]  req_second_index;
   logic signed [15:0] req_coord_x;
   logic signed [15:0] req_coord_y;
   logic signed [15:0] req_coord_z;
   logic [15:0] req_pair_weight;
   logic        rsp_valid;
   logic [39:0] rsp_energy_total;
   logic signed [31:0] rsp_grad_x;
   logic signed [31:0] rsp_grad_y;
   logic signed [31:0] rsp_grad_z;
   logic        rsp_coincident_flag;

   pair_energy_scoreboard sb = new();
   bit     loaded[NPTS];
   int     idle_pct;
   longint cycles = 0;

   weighted_pair_repulsion_energy dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_point_index(req_point_index),
      .req_second_index(req_second_index), .req_coord_x(req_coord_x),
      .req_coord_y(req_coord_y), .req_coord_z(req_coord_z),
      .req_pair_weight(req_pair_weight), .rsp_valid(rsp_valid),
      .rsp_energy_total(rsp_energy_total), .rsp_grad_x(rsp_grad_x),
      .rsp_grad_y(rsp_grad_y), .rsp_grad_z(rsp_grad_z),
      .rsp_coincident_flag(rsp_coincident_flag)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("** weighted_pair_repulsion_energy: FAILED **");
         $finish;
      end
   end

   // results first: a result always belongs to a word accepted earlier
   always @(posedge clock) begin
      result_word got;
      if (!reset) begin
         if (rsp_valid) begin
            got.energy = rsp_energy_total;
            got.gx = rsp_grad_x;
            got.gy = rsp_grad_y;
            got.gz = rsp_grad_z;
            got.flag = rsp_coincident_flag;
            sb.check_word(got);
         end
         if (start && !busy)
            sb.note_word(action_type'(req_action), req_point_index, req_second_index,
                         req_coord_x, req_coord_y, req_coord_z, req_pair_weight);
      end
   end

   task send_word(action_type act, int a, int b, logic [15:0] x, logic [15:0] y,
                  logic [15:0] z, logic [15:0] w);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1;
      req_action <= act;
      req_point_index <= a[5:0];
      req_second_index <= b[5:0];
      req_coord_x <= x;
      req_coord_y <= y;
      req_coord_z <= z;
      req_pair_weight <= w;
      do @(posedge clock); while (busy);
      if (act == ACT_LOAD) loaded[a] = 1;
   endtask

   function automatic int pick_loaded();
      int i;
      do i = $urandom_range(NPTS - 1); while (!loaded[i]);
      return i;
   endfunction

   function automatic logic [15:0] pick_coord(int near, int k);
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
         2: return 16'($signed($urandom_range(64)) - 32);
         default: return sb.coords[near][k] + 16'($signed($urandom_range(8)) - 4);
      endcase
   endfunction

   function automatic logic [15:0] pick_weight();
      case ($urandom_range(3))
         0: return 16'hFFFF;
         1: return 16'($urandom_range(16));
         default: return 16'($urandom);
      endcase
   endfunction

   task random_word();
      int sel;
      int a;
      int b;
      sel = $urandom_range(99);
      if (sel < 22) begin
         a = $urandom_range(NPTS - 1);
         b = pick_loaded();
         send_word(ACT_LOAD, a, $urandom_range(NPTS - 1), pick_coord(b, 0),
                   pick_coord(b, 1), pick_coord(b, 2), 16'($urandom));
      end else if (sel < 75) begin
         a = pick_loaded();
         b = $urandom_range(19) == 0 ? a : pick_loaded();
         send_word(ACT_PAIR, a, b, 16'($urandom), 16'($urandom), 16'($urandom),
                   pick_weight());
      end else if (sel < 98) begin
         send_word(ACT_READ, $urandom_range(NPTS - 1), $urandom_range(NPTS - 1),
                   16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
         send_word(ACT_CLEAR, $urandom_range(NPTS - 1), $urandom_range(NPTS - 1),
                   16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end
   endtask

   initial begin
      reset = 1;
      start = 0;
      req_action = ACT_LOAD;
      req_point_index = '0;
      req_second_index = '0;
      req_coord_x = '0;
      req_coord_y = '0;
      req_coord_z = '0;
      req_pair_weight = '0;
      idle_pct = 0;
      foreach (loaded[i]) loaded[i] = 0;
      repeat (8) @(posedge clock);
      reset <= 0;

      // directed: extremes, coincidence, saturation, clear
      send_word(ACT_LOAD, 0, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_word(ACT_LOAD, 1, 0, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
      send_word(ACT_LOAD, 2, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
      send_word(ACT_LOAD, 3, 63, 16'h8000, 16'h8000, 16'h8000, 16'h0000);
      send_word(ACT_LOAD, 4, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_word(ACT_LOAD, 63, 63, 16'hFFFF, 16'h0001, 16'h8001, 16'h0000);
      send_word(ACT_PAIR, 0, 1, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
      send_word(ACT_PAIR, 0, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_word(ACT_PAIR, 0, 4, 16'h0000, 16'h0000, 16'h0000, 16'h0100);
      send_word(ACT_PAIR, 2, 3, 16'h0000, 16'h0000, 16'h0000, 16'h0001);
      send_word(ACT_PAIR, 3, 2, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
      send_word(ACT_PAIR, 1, 63, 16'h0000, 16'h0000, 16'h0000, 16'h8000);
      send_word(ACT_READ, 0, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_word(ACT_READ, 1, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_word(ACT_READ, 2, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_word(ACT_READ, 3, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_word(ACT_READ, 63, 63, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_word(ACT_CLEAR, 0, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_word(ACT_READ, 0, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_word(ACT_PAIR, 2, 3, 16'h0000, 16'h0000, 16'h0000, 16'h0100);
      send_word(ACT_READ, 2, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);

      for (int n = 0; n < RAND_WORDS; n++) begin
         idle_pct = n < 300 ? 24 : (n < 600 ? 87 : 0);
         random_word();
      end
      start <= 0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      $display("covered %0d loads, %0d pairs (%0d coincident), %0d reads, %0d clears",
               sb.per_action[ACT_LOAD], sb.per_action[ACT_PAIR], sb.coincident_pairs,
               sb.per_action[ACT_READ], sb.per_action[ACT_CLEAR]);
      $display("%0d results compared, %0d mismatches", sb.checked, sb.errors);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("** weighted_pair_repulsion_energy: PASSED **");
      else
         $display("** weighted_pair_repulsion_energy: FAILED **");
      $finish;
   end

endmodule

FILE: filelist.f
design/wpre_pkg.sv
design/wpre_ram.sv
design/wpre_div.sv
design/wpre_datapath.sv
design/wpre_ctrl.sv
design/weighted_pair_repulsion_energy.sv
tb/sv/testbench.sv
